[rtl/core/pal_pkg.sv]
package pal_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int NAME_W   = 64;
	localparam int ID_W     = 37;
	localparam int POS_W    = 6;
	localparam int STAT_W   = 2;
	localparam int REQ_W    = 2;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_POS   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [NAME_W-1:0] name;
		logic [ID_W-1:0]   id;
	} rec_t;

	// broadcast to every cell for one transaction
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic [CNT_W-1:0] ins_slot;
		logic [CNT_W-1:0] rem_slot;
		logic [CNT_W-1:0] count;
		rec_t             key;
	} cell_ctrl_t;

endpackage

[rtl/core/pal_req_if.sv]
interface pal_req_if;
	logic                        valid;
	logic                        ready;
	logic [pal_pkg::REQ_W-1:0]   req_type;
	logic [pal_pkg::POS_W-1:0]   position;
	logic [pal_pkg::NAME_W-1:0]  entry_name;
	logic [pal_pkg::ID_W-1:0]    entry_id;

	modport source (output valid, output req_type, output position, output entry_name,
		output entry_id, input ready);
	modport sink (input valid, input req_type, input position, input entry_name,
		input entry_id, output ready);
endinterface

[rtl/core/pal_rsp_if.sv]
interface pal_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pal_pkg::STAT_W-1:0]  status;
	logic [pal_pkg::POS_W-1:0]   found_index;
	logic [pal_pkg::NAME_W-1:0]  out_name;
	logic [pal_pkg::ID_W-1:0]    out_id;
	logic [pal_pkg::POS_W-1:0]   entry_count;

	modport source (output valid, output status, output found_index, output out_name,
		output out_id, output entry_count, input ready);
	modport sink (input valid, input status, input found_index, input out_name,
		input out_id, input entry_count, output ready);
endinterface

[rtl/core/positional_array_list.sv]
// Ordered list of up to pal_pkg::CAPACITY client records held in a row of cells,
// one record per cell. Insert and remove shift all cells above the slot in
// parallel, and search compares both keys in every cell at once and picks the
// lowest match with a priority encoder. The response is registered and appears
// the cycle after the request is accepted; a new request is taken every cycle as
// long as the response side keeps up.
module positional_array_list (
	input  logic      clk,
	input  logic      arst_n,
	pal_req_if.sink   req,
	pal_rsp_if.source rsp
);

	localparam int N = pal_pkg::CAPACITY;

	logic [pal_pkg::CNT_W-1:0] count_q;
	logic [pal_pkg::CNT_W-1:0] count_nxt;
	logic                      rsp_valid_q;
	logic [pal_pkg::STAT_W-1:0] status_q;
	logic [pal_pkg::POS_W-1:0]  found_q;
	logic [pal_pkg::NAME_W-1:0] name_q;
	logic [pal_pkg::ID_W-1:0]   id_q;
	logic [pal_pkg::POS_W-1:0]  cnt_out_q;

	logic                      accept;
	logic                      full;
	logic                      rem_ok;
	logic [pal_pkg::CMP_W-1:0] pos_ext;
	logic [pal_pkg::CMP_W-1:0] cnt_ext;
	logic [pal_pkg::CMP_W-1:0] pos_dec;
	pal_pkg::req_type_t        rtype;
	pal_pkg::cell_ctrl_t       ctrl;

	pal_pkg::rec_t   recs [N];
	pal_pkg::rec_t   rds  [N];
	logic [N-1:0]    match_vec;

	logic                      hit;
	logic [pal_pkg::IDX_W-1:0] hit_idx;
	pal_pkg::rec_t             rd_rec;
	logic [pal_pkg::STAT_W-1:0] status_nxt;
	logic [pal_pkg::POS_W-1:0]  found_nxt;
	logic [pal_pkg::CNT_W-1:0]  hit_pos;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign rtype     = pal_pkg::req_type_t'(req.req_type);

	assign pos_ext = pal_pkg::CMP_W'(req.position);
	assign cnt_ext = pal_pkg::CMP_W'(count_q);
	assign pos_dec = pos_ext - 1'b1;
	assign full    = (cnt_ext == pal_pkg::CMP_W'(N));
	assign rem_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

	always_comb begin
		ctrl.ins      = accept && (rtype == pal_pkg::REQ_INSERT) && !full;
		ctrl.rem      = accept && (rtype == pal_pkg::REQ_REMOVE) && rem_ok;
		// a slot past the end appends
		ctrl.ins_slot = (pos_ext > cnt_ext) ? count_q : pos_ext[pal_pkg::CNT_W-1:0];
		ctrl.rem_slot = pos_dec[pal_pkg::CNT_W-1:0];
		ctrl.count    = count_q;
		ctrl.key.name = req.entry_name;
		ctrl.key.id   = req.entry_id;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		pal_pkg::rec_t left_rec;
		pal_pkg::rec_t right_rec;

		if (i == 0) begin : g_first
			assign left_rec = '0;
		end else begin : g_left
			assign left_rec = recs[i-1];
		end
		if (i == N - 1) begin : g_last
			assign right_rec = '0;
		end else begin : g_right
			assign right_rec = recs[i+1];
		end

		pal_cell u_cell (
			.clk   (clk),
			.idx   (pal_pkg::IDX_W'(i)),
			.ctrl  (ctrl),
			.left  (left_rec),
			.right (right_rec),
			.rec   (recs[i]),
			.match (match_vec[i]),
			.rd    (rds[i])
		);
	end

	// lowest matching cell wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				hit     = 1'b1;
				hit_idx = pal_pkg::IDX_W'(i);
			end
		end
	end

	always_comb begin
		rd_rec = '0;
		for (int i = 0; i < N; i++) begin
			rd_rec = rd_rec | rds[i];
		end
	end

	assign hit_pos = pal_pkg::CNT_W'(hit_idx) + 1'b1;

	always_comb begin
		count_nxt  = count_q;
		status_nxt = pal_pkg::ST_OK;
		found_nxt  = '0;
		case (rtype)
			pal_pkg::REQ_INSERT: begin
				if (full) begin
					status_nxt = pal_pkg::ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
				end
			end
			pal_pkg::REQ_REMOVE: begin
				if (rem_ok) begin
					count_nxt = count_q - 1'b1;
				end else begin
					status_nxt = pal_pkg::ST_BAD_POS;
				end
			end
			pal_pkg::REQ_SEARCH: begin
				if (hit) begin
					found_nxt = pal_pkg::POS_W'(hit_pos);
				end else begin
					status_nxt = pal_pkg::ST_NOT_FOUND;
				end
			end
			pal_pkg::REQ_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
				count_nxt = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_nxt;
			found_q   <= found_nxt;
			name_q    <= ctrl.rem ? rd_rec.name : '0;
			id_q      <= ctrl.rem ? rd_rec.id : '0;
			cnt_out_q <= pal_pkg::POS_W'(count_nxt);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.found_index = found_q;
	assign rsp.out_name    = name_q;
	assign rsp.out_id      = id_q;
	assign rsp.entry_count = cnt_out_q;

endmodule

[rtl/core/pal_cell.sv]
module pal_cell (
	input  logic                      clk,
	input  logic [pal_pkg::IDX_W-1:0] idx,
	input  pal_pkg::cell_ctrl_t       ctrl,
	input  pal_pkg::rec_t             left,
	input  pal_pkg::rec_t             right,
	output pal_pkg::rec_t             rec,
	output logic                      match,
	output pal_pkg::rec_t             rd
);

	pal_pkg::rec_t rec_q;
	pal_pkg::rec_t rec_nxt;
	logic          we;
	logic [pal_pkg::CNT_W-1:0] pos;
	logic [pal_pkg::CNT_W-1:0] pos_inc;

	assign pos     = pal_pkg::CNT_W'(idx);
	assign pos_inc = pos + 1'b1;

	always_comb begin
		rec_nxt = rec_q;
		we      = 1'b0;
		if (ctrl.ins) begin
			if (pos == ctrl.ins_slot) begin
				rec_nxt = ctrl.key;
				we      = 1'b1;
			end else if (pos > ctrl.ins_slot && pos <= ctrl.count) begin
				// open the gap: take the record from below
				rec_nxt = left;
				we      = 1'b1;
			end
		end else if (ctrl.rem) begin
			if (pos >= ctrl.rem_slot && pos_inc < ctrl.count) begin
				// close the gap: take the record from above
				rec_nxt = right;
				we      = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			rec_q <= rec_nxt;
		end
	end

	assign rec   = rec_q;
	assign match = (pos < ctrl.count) && (rec_q == ctrl.key);
	assign rd    = (pos == ctrl.rem_slot) ? rec_q : '0;

endmodule
